// File: src/adamu_pkg.sv
// ----------------------------------------------------------------------------
// Adam update unit package
// Shared types, constants and the step functions of the divide and root pipes.
// ----------------------------------------------------------------------------
package adamu_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [24:0] Q24_ONE = 25'h100_0000;

   localparam int VH_STEPS = 64;
   localparam int MH_STEPS = 56;
   localparam int SQ_STEPS = 32;
   localparam int RT_STEPS = 39;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_BETA_FIRST    = 2'd1,
      CSR_BETA_SECOND   = 2'd2,
      CSR_EPSILON       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [11:0] idx;
      logic [31:0] cur;
      logic        neg;
      logic [24:0] dm;
      logic [24:0] mrem;
      logic [55:0] mq;
      logic [24:0] dv;
      logic [24:0] vrem;
      logic [63:0] vq;
      logic        vovf;
   } ph1_type;

   typedef struct packed {
      logic [11:0] idx;
      logic [31:0] cur;
      logic        neg;
      logic [55:0] mhat;
      logic [63:0] xs;
      logic [33:0] rem;
      logic [31:0] res;
   } ph2_type;

   typedef struct packed {
      logic [11:0] idx;
      logic [31:0] cur;
      logic        neg;
      logic        zero;
      logic        ovf;
      logic [40:0] den;
      logic [40:0] rem;
      logic [38:0] qd;
   } ph3_type;

   // Computes floor(x * b / 2^24) modulo 2^64.
   function automatic logic [63:0] mul_q24(logic [63:0] x, logic [24:0] b);
      logic [56:0] ph;
      logic [56:0] pl;
      ph = 57'(x[63:32]) * 57'(b);
      pl = 57'(x[31:0]) * 57'(b);
      return 64'({ph, 8'b0}) + 64'(pl >> 24);
   endfunction

   function automatic ph1_type ph1_step(ph1_type s, logic mstep);
      ph1_type r;
      logic [25:0] tv;
      logic [25:0] tm;
      r = s;
      tv = {s.vrem, s.vq[63]};
      if (tv >= {1'b0, s.dv}) begin
         r.vrem = 25'(tv - {1'b0, s.dv});
         r.vq = {s.vq[62:0], 1'b1};
      end else begin
         r.vrem = tv[24:0];
         r.vq = {s.vq[62:0], 1'b0};
      end
      tm = {s.mrem, s.mq[55]};
      if (mstep) begin
         if (tm >= {1'b0, s.dm}) begin
            r.mrem = 25'(tm - {1'b0, s.dm});
            r.mq = {s.mq[54:0], 1'b1};
         end else begin
            r.mrem = tm[24:0];
            r.mq = {s.mq[54:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic ph2_type ph2_step(ph2_type s);
      ph2_type r;
      logic [35:0] t;
      logic [35:0] trial;
      r = s;
      t = {s.rem, s.xs[63:62]};
      trial = {2'b0, s.res, 2'b01};
      if (t >= trial) begin
         r.rem = 34'(t - trial);
         r.res = {s.res[30:0], 1'b1};
      end else begin
         r.rem = t[33:0];
         r.res = {s.res[30:0], 1'b0};
      end
      r.xs = {s.xs[61:0], 2'b00};
      return r;
   endfunction

   function automatic ph3_type ph3_step(ph3_type s);
      ph3_type r;
      logic [41:0] t;
      r = s;
      t = {s.rem, s.qd[38]};
      if (t >= {1'b0, s.den}) begin
         r.rem = 41'(t - {1'b0, s.den});
         r.qd = {s.qd[37:0], 1'b1};
      end else begin
         r.rem = t[40:0];
         r.qd = {s.qd[37:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: src/adam_optimizer_update_unit.sv
// ----------------------------------------------------------------------------
// Adam optimizer update unit
// The pipeline depth is set mostly by the one-bit-per-stage divide and square
// root pipes; one transaction is taken per cycle while req_stall is low. A
// stalled result holds the whole pipe and raises req_stall. After reset the
// moment memories are cleared, during which req_stall stays high.
// ----------------------------------------------------------------------------
module adam_optimizer_update_unit #(
   parameter int ELEMENT_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [11:0]                   req_element_index,
   input  logic signed [31:0]            req_gradient,
   input  logic signed [31:0]            req_current_value,
   input  logic                          req_step_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [11:0]                   rsp_result_index,
   output logic signed [31:0]            rsp_new_value,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  adamu_pkg::csr_index_type      csr_index,
   input  logic [31:0]                   csr_write_data
);
   import adamu_pkg::*;

   localparam int AW = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
   localparam int RECIP = (1 << 24) / ELEMENT_DEPTH;

   logic adv;

   logic [23:0] learning_rate_ff;
   logic [23:0] beta_first_ff;
   logic [23:0] beta_second_ff;
   logic [31:0] epsilon_ff;
   logic [23:0] pow1_ff;
   logic [23:0] pow2_ff;

   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   logic [31:0] mem_m [ELEMENT_DEPTH];
   logic [63:0] mem_v [ELEMENT_DEPTH];

   // Input stage.
   logic               a_vld_ff;
   logic [11:0]        a_idx_ff;
   logic signed [31:0] a_grad_ff;
   logic signed [31:0] a_cur_ff;
   logic               a_start_ff;
   logic [24:0]        a_one_m_b1;
   logic signed [57:0] a_gterm1_in;
   logic [31:0]        a_gabs;
   logic [63:0]        a_gsq_in;
   logic [39:0]        a_prod;
   logic [23:0]        a_pow1_in;
   logic [23:0]        a_pow2_in;

   // Address and second moment gradient term.
   logic               b_vld_ff;
   logic [11:0]        b_idx_ff;
   logic signed [31:0] b_cur_ff;
   logic signed [57:0] b_gterm1_ff;
   logic [63:0]        b_gsq_ff;
   logic [11:0]        b_quot_ff;
   logic [23:0]        b_pow1_ff;
   logic [23:0]        b_pow2_ff;
   logic [32:0]        b_qd;
   logic [12:0]        b_rem;
   logic [31:0]        b_red;
   logic [AW-1:0]      b_addr;
   logic [63:0]        b_gterm2_in;

   // Moment update.
   logic               c_vld_ff;
   logic [11:0]        c_idx_ff;
   logic signed [31:0] c_cur_ff;
   logic [AW-1:0]      c_addr_ff;
   logic signed [57:0] c_gterm1_ff;
   logic [63:0]        c_gterm2_ff;
   logic [24:0]        c_dm_ff;
   logic [24:0]        c_dv_ff;
   logic signed [31:0] rd_m_ff;
   logic [63:0]        rd_v_ff;
   logic               c_fwd;
   logic signed [31:0] c_m_old;
   logic [63:0]        c_v_old;
   logic signed [57:0] c_mprod;
   logic signed [57:0] c_msum;
   logic signed [57:0] c_mshift;
   logic signed [31:0] c_m_in;
   logic [63:0]        c_v_in;

   logic               d_vld_ff;
   logic [11:0]        d_idx_ff;
   logic signed [31:0] d_cur_ff;
   logic [AW-1:0]      d_addr_ff;
   logic signed [31:0] d_m_ff;
   logic [63:0]        d_v_ff;
   logic [24:0]        d_dm_ff;
   logic [24:0]        d_dv_ff;
   logic [31:0]        d_mmag;

   ph1_type p1_head;
   ph1_type p1_ff [1:VH_STEPS];
   logic    p1_vld_ff [1:VH_STEPS];

   ph2_type p2_head;
   ph2_type p2_ff [1:SQ_STEPS];
   logic    p2_vld_ff [1:SQ_STEPS];

   logic        dq_vld_ff;
   logic [11:0] dq_idx_ff;
   logic [31:0] dq_cur_ff;
   logic        dq_neg_ff;
   logic [55:0] dq_mhat_ff;
   logic [40:0] dq_den_ff;
   logic [48:0] dq_hi;

   ph3_type p3_head;
   ph3_type p3_ff [1:RT_STEPS];
   logic    p3_vld_ff [1:RT_STEPS];
   logic [39:0] rt_ratio;

   logic               mu_vld_ff;
   logic [11:0]        mu_idx_ff;
   logic signed [31:0] mu_cur_ff;
   logic               mu_neg_ff;
   logic [43:0]        mu_ph_ff;
   logic [43:0]        mu_pl_ff;

   logic [63:0]        f_sum;
   logic [39:0]        f_step;
   logic signed [41:0] f_cur;
   logic signed [41:0] f_nv;
   logic signed [31:0] f_value_in;
   logic               f_sat_in;

   logic               rsp_valid_ff;
   logic [11:0]        rsp_idx_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_sat_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || clr_active_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         learning_rate_ff <= 24'd16777;
         beta_first_ff    <= 24'd15099494;
         beta_second_ff   <= 24'd16760438;
         epsilon_ff       <= 32'd43;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: learning_rate_ff <= csr_write_data[23:0];
            CSR_BETA_FIRST:    beta_first_ff    <= csr_write_data[23:0];
            CSR_BETA_SECOND:   beta_second_ff   <= csr_write_data[23:0];
            CSR_EPSILON:       epsilon_ff       <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(ELEMENT_DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_comb begin
      a_one_m_b1  = Q24_ONE - 25'(beta_first_ff);
      a_gterm1_in = 58'($signed({1'b0, a_one_m_b1})) * 58'(a_grad_ff);
      a_gabs      = a_grad_ff[31] ? 32'(-a_grad_ff) : 32'(a_grad_ff);
      a_gsq_in    = 64'(a_gabs) * 64'(a_gabs);
      a_prod      = 40'(a_idx_ff) * 40'(RECIP);
      a_pow1_in   = pow1_ff;
      a_pow2_in   = pow2_ff;
      if (a_start_ff) begin
         a_pow1_in = 24'((48'(pow1_ff) * 48'(beta_first_ff)) >> 24);
         a_pow2_in = 24'((48'(pow2_ff) * 48'(beta_second_ff)) >> 24);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         pow1_ff  <= 24'hFF_FFFF;
         pow2_ff  <= 24'hFF_FFFF;
      end else if (adv) begin
         a_vld_ff <= req_valid && !clr_active_ff;
         if (a_vld_ff) begin
            pow1_ff <= a_pow1_in;
            pow2_ff <= a_pow2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_idx_ff    <= req_element_index;
         a_grad_ff   <= req_gradient;
         a_cur_ff    <= req_current_value;
         a_start_ff  <= req_step_start;
         b_idx_ff    <= a_idx_ff;
         b_cur_ff    <= a_cur_ff;
         b_gterm1_ff <= a_gterm1_in;
         b_gsq_ff    <= a_gsq_in;
         b_quot_ff   <= a_prod[35:24];
         b_pow1_ff   <= a_pow1_in;
         b_pow2_ff   <= a_pow2_in;
      end
   end

   always_comb begin
      b_qd  = 33'(b_quot_ff) * 33'(ELEMENT_DEPTH);
      b_rem = {1'b0, b_idx_ff} - b_qd[12:0];
      b_red = 32'(b_rem);
      if (b_red >= 32'(ELEMENT_DEPTH)) begin
         b_red = b_red - 32'(ELEMENT_DEPTH);
      end
      b_addr      = b_red[AW-1:0];
      b_gterm2_in = mul_q24(b_gsq_ff, Q24_ONE - 25'(beta_second_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_idx_ff    <= b_idx_ff;
         c_cur_ff    <= b_cur_ff;
         c_addr_ff   <= b_addr;
         c_gterm1_ff <= b_gterm1_ff;
         c_gterm2_ff <= b_gterm2_in;
         c_dm_ff     <= Q24_ONE - 25'(b_pow1_ff);
         c_dv_ff     <= Q24_ONE - 25'(b_pow2_ff);
         rd_m_ff     <= mem_m[b_addr];
         rd_v_ff     <= mem_v[b_addr];
      end
   end

   // The moment of the transaction one stage ahead is not yet in the read data.
   always_comb begin
      c_fwd    = d_vld_ff && (d_addr_ff == c_addr_ff);
      c_m_old  = c_fwd ? d_m_ff : rd_m_ff;
      c_v_old  = c_fwd ? d_v_ff : rd_v_ff;
      c_mprod  = 58'($signed({1'b0, beta_first_ff})) * 58'(c_m_old);
      c_msum   = c_mprod + c_gterm1_ff;
      c_mshift = c_msum >>> 24;
      if (c_mshift[57:31] == {27{c_mshift[57]}}) begin
         c_m_in = c_mshift[31:0];
      end else if (c_mshift[57]) begin
         c_m_in = 32'sh8000_0000;
      end else begin
         c_m_in = 32'sh7FFF_FFFF;
      end
      c_v_in = mul_q24(c_v_old, {1'b0, beta_second_ff}) + c_gterm2_ff;
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem_m[clr_addr_ff] <= '0;
         mem_v[clr_addr_ff] <= '0;
      end else if (adv && c_vld_ff) begin
         mem_m[c_addr_ff] <= c_m_in;
         mem_v[c_addr_ff] <= c_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_idx_ff  <= c_idx_ff;
         d_cur_ff  <= c_cur_ff;
         d_addr_ff <= c_addr_ff;
         d_m_ff    <= c_m_in;
         d_v_ff    <= c_v_in;
         d_dm_ff   <= c_dm_ff;
         d_dv_ff   <= c_dv_ff;
      end
   end

   always_comb begin
      d_mmag       = d_m_ff[31] ? 32'(-d_m_ff) : 32'(d_m_ff);
      p1_head.idx  = d_idx_ff;
      p1_head.cur  = d_cur_ff;
      p1_head.neg  = d_m_ff[31];
      p1_head.dm   = d_dm_ff;
      p1_head.mrem = '0;
      p1_head.mq   = {d_mmag, 24'b0};
      p1_head.dv   = d_dv_ff;
      p1_head.vrem = {1'b0, d_v_ff[63:40]};
      p1_head.vq   = {d_v_ff[39:0], 24'b0};
      p1_head.vovf = {1'b0, d_v_ff} >= {d_dv_ff, 40'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff[1] <= ph1_step(p1_head, 1'b1);
         for (int k = 2; k <= VH_STEPS; k++) begin
            p1_ff[k] <= ph1_step(p1_ff[k-1], (k - 1) < MH_STEPS);
         end
      end
   end

   always_comb begin
      p2_head.idx  = p1_ff[VH_STEPS].idx;
      p2_head.cur  = p1_ff[VH_STEPS].cur;
      p2_head.neg  = p1_ff[VH_STEPS].neg;
      p2_head.mhat = p1_ff[VH_STEPS].mq;
      p2_head.xs   = p1_ff[VH_STEPS].vovf ? '1 : p1_ff[VH_STEPS].vq;
      p2_head.rem  = '0;
      p2_head.res  = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff[1] <= ph2_step(p2_head);
         for (int k = 2; k <= SQ_STEPS; k++) begin
            p2_ff[k] <= ph2_step(p2_ff[k-1]);
         end
         dq_idx_ff  <= p2_ff[SQ_STEPS].idx;
         dq_cur_ff  <= p2_ff[SQ_STEPS].cur;
         dq_neg_ff  <= p2_ff[SQ_STEPS].neg;
         dq_mhat_ff <= p2_ff[SQ_STEPS].mhat;
         dq_den_ff  <= 41'({p2_ff[SQ_STEPS].res, 8'b0}) + 41'(epsilon_ff);
      end
   end

   always_comb begin
      dq_hi        = dq_mhat_ff[55:7];
      p3_head.idx  = dq_idx_ff;
      p3_head.cur  = dq_cur_ff;
      p3_head.neg  = dq_neg_ff;
      p3_head.zero = dq_den_ff == '0;
      p3_head.ovf  = dq_hi >= 49'(dq_den_ff);
      p3_head.den  = dq_den_ff;
      p3_head.rem  = p3_head.ovf ? '0 : dq_hi[40:0];
      p3_head.qd   = {dq_mhat_ff[6:0], 32'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_ff[1] <= ph3_step(p3_head);
         for (int k = 2; k <= RT_STEPS; k++) begin
            p3_ff[k] <= ph3_step(p3_ff[k-1]);
         end
      end
   end

   always_comb begin
      if (p3_ff[RT_STEPS].zero) begin
         rt_ratio = '0;
      end else if (p3_ff[RT_STEPS].ovf) begin
         rt_ratio = 40'h80_0000_0000;
      end else begin
         rt_ratio = {1'b0, p3_ff[RT_STEPS].qd};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_idx_ff <= p3_ff[RT_STEPS].idx;
         mu_cur_ff <= p3_ff[RT_STEPS].cur;
         mu_neg_ff <= p3_ff[RT_STEPS].neg;
         mu_ph_ff  <= 44'(learning_rate_ff) * 44'(rt_ratio[39:20]);
         mu_pl_ff  <= 44'(learning_rate_ff) * 44'(rt_ratio[19:0]);
      end
   end

   always_comb begin
      f_sum  = {mu_ph_ff, 20'b0} + 64'(mu_pl_ff);
      f_step = f_sum[63:24];
      f_cur  = 42'(mu_cur_ff);
      if (mu_neg_ff) begin
         f_nv = f_cur + $signed({2'b0, f_step});
      end else begin
         f_nv = f_cur - $signed({2'b0, f_step});
      end
      if (f_nv[41:31] == {11{f_nv[41]}}) begin
         f_value_in = f_nv[31:0];
         f_sat_in   = 1'b0;
      end else begin
         f_value_in = f_nv[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         f_sat_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff   <= mu_idx_ff;
         rsp_value_ff <= f_value_in;
         rsp_sat_ff   <= f_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         dq_vld_ff    <= 1'b0;
         mu_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 1; k <= VH_STEPS; k++) begin
            p1_vld_ff[k] <= 1'b0;
         end
         for (int k = 1; k <= SQ_STEPS; k++) begin
            p2_vld_ff[k] <= 1'b0;
         end
         for (int k = 1; k <= RT_STEPS; k++) begin
            p3_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         p1_vld_ff[1] <= d_vld_ff;
         for (int k = 2; k <= VH_STEPS; k++) begin
            p1_vld_ff[k] <= p1_vld_ff[k-1];
         end
         p2_vld_ff[1] <= p1_vld_ff[VH_STEPS];
         for (int k = 2; k <= SQ_STEPS; k++) begin
            p2_vld_ff[k] <= p2_vld_ff[k-1];
         end
         dq_vld_ff    <= p2_vld_ff[SQ_STEPS];
         p3_vld_ff[1] <= dq_vld_ff;
         for (int k = 2; k <= RT_STEPS; k++) begin
            p3_vld_ff[k] <= p3_vld_ff[k-1];
         end
         mu_vld_ff    <= p3_vld_ff[RT_STEPS];
         rsp_valid_ff <= mu_vld_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_new_value    = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule
